// ===== hdl/pba_pkg.sv =====
package pba_pkg;

   localparam int MAX_PAGES_DEFAULT = 16384;
   localparam int ADDR_W = 32;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT;
   localparam int COUNT_W = PAGE_NUM_W + 1;
   localparam int PAGE_COUNT_W = 15;
   localparam int WORD_BITS = 32;
   localparam int BIT_SEL_W = 5;
   localparam logic [PAGE_COUNT_W-1:0] PAGE_COUNT_RESET = 15'd16384;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_ALLOC = 2'd0;
   localparam kind_type KIND_FREE = 2'd1;
   localparam kind_type KIND_RESERVE = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_OOM,
      STATUS_UNALIGNED,
      STATUS_RANGE
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_UPDATE,
      S_RESPOND
   } state_type;

   function automatic logic [BIT_SEL_W-1:0] first_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_SEL_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_SEL_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hdl/pba_if.sv =====
interface pba_req_if;
   logic valid;
   logic ready;
   pba_pkg::kind_type kind;
   logic [pba_pkg::ADDR_W-1:0] address;

   modport source (output valid, output kind, output address, input ready);
   modport sink (input valid, input kind, input address, output ready);
endinterface

interface pba_rsp_if;
   logic valid;
   logic ready;
   logic [pba_pkg::ADDR_W-1:0] page_address;
   pba_pkg::status_type status;

   modport source (output valid, output page_address, output status, input ready);
   modport sink (input valid, input page_address, input status, output ready);
endinterface

// ===== hdl/page_bitmap_allocator.sv =====
// Channel   Direction  Handshake     Payload
// req_ch    in         valid/ready   kind, address
// rsp_ch    out        valid/ready   page_address, status
// csr       in         csr_wr_en     csr_wr_data (page count)
//
// After reset a clearing pass marks every page used, one bitmap word per cycle
// (512 words at the default size); no item is taken until it ends.
// Free, reserve or unused kinds pass CHECK; UPDATE or RESPOND then registers the result.
// An allocate walks the summary of non-full words one entry per cycle in SCAN; UPDATE
// then writes the chosen free bit and registers its result.
// Items are taken while a result is shown; a result not taken stalls the next result.
module page_bitmap_allocator #(
   parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   pba_req_if.sink req_ch,
   pba_rsp_if.source rsp_ch,
   input  logic csr_wr_en,
   input  logic [pba_pkg::PAGE_COUNT_W-1:0] csr_wr_data
);

   localparam int WORDS = (MAX_PAGES + 31) / 32;
   localparam int WAW = WORDS > 1 ? $clog2(WORDS) : 1;
   localparam int SUM_WORDS = (WORDS + 31) / 32;
   localparam int SAW = SUM_WORDS > 1 ? $clog2(SUM_WORDS) : 1;
   localparam int DW = pba_pkg::WORD_BITS;

   logic [pba_pkg::PAGE_COUNT_W-1:0] page_count_ff;

   logic bm_wr_en;
   logic [WAW-1:0] bm_wr_addr;
   logic [DW-1:0] bm_wr_data;
   logic bm_rd_en;
   logic [WAW-1:0] bm_rd_addr;
   logic [DW-1:0] bm_rd_data;
   logic sum_wr_en;
   logic [SAW-1:0] sum_wr_addr;
   logic [DW-1:0] sum_wr_data;
   logic sum_rd_en;
   logic [SAW-1:0] sum_rd_addr;
   logic [DW-1:0] sum_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= pba_pkg::PAGE_COUNT_RESET;
      end else if (csr_wr_en) begin
         page_count_ff <= csr_wr_data;
      end
   end

   pba_ram #(
      .WIDTH (DW),
      .DEPTH (WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_en   (bm_rd_en),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   pba_ram #(
      .WIDTH (DW),
      .DEPTH (SUM_WORDS)
   ) u_summary (
      .clock   (clock),
      .wr_en   (sum_wr_en),
      .wr_addr (sum_wr_addr),
      .wr_data (sum_wr_data),
      .rd_en   (sum_rd_en),
      .rd_addr (sum_rd_addr),
      .rd_data (sum_rd_data)
   );

   pba_ctrl #(
      .MAX_PAGES (MAX_PAGES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .page_count  (page_count_ff),
      .bm_wr_en    (bm_wr_en),
      .bm_wr_addr  (bm_wr_addr),
      .bm_wr_data  (bm_wr_data),
      .bm_rd_en    (bm_rd_en),
      .bm_rd_addr  (bm_rd_addr),
      .bm_rd_data  (bm_rd_data),
      .sum_wr_en   (sum_wr_en),
      .sum_wr_addr (sum_wr_addr),
      .sum_wr_data (sum_wr_data),
      .sum_rd_en   (sum_rd_en),
      .sum_rd_addr (sum_rd_addr),
      .sum_rd_data (sum_rd_data)
   );

endmodule

// ===== hdl/pba_ram.sv =====
module pba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pba_ctrl.sv =====
module pba_ctrl #(
   parameter int MAX_PAGES = pba_pkg::MAX_PAGES_DEFAULT,
   localparam int WORDS = (MAX_PAGES + 31) / 32,
   localparam int WAW = WORDS > 1 ? $clog2(WORDS) : 1,
   localparam int SUM_WORDS = (WORDS + 31) / 32,
   localparam int SAW = SUM_WORDS > 1 ? $clog2(SUM_WORDS) : 1
) (
   input  logic clock,
   input  logic reset,
   pba_req_if.sink req_ch,
   pba_rsp_if.source rsp_ch,
   input  logic [pba_pkg::PAGE_COUNT_W-1:0] page_count,
   output logic bm_wr_en,
   output logic [WAW-1:0] bm_wr_addr,
   output logic [pba_pkg::WORD_BITS-1:0] bm_wr_data,
   output logic bm_rd_en,
   output logic [WAW-1:0] bm_rd_addr,
   input  logic [pba_pkg::WORD_BITS-1:0] bm_rd_data,
   output logic sum_wr_en,
   output logic [SAW-1:0] sum_wr_addr,
   output logic [pba_pkg::WORD_BITS-1:0] sum_wr_data,
   output logic sum_rd_en,
   output logic [SAW-1:0] sum_rd_addr,
   input  logic [pba_pkg::WORD_BITS-1:0] sum_rd_data
);

   localparam int CW = pba_pkg::COUNT_W;
   localparam int BW = pba_pkg::BIT_SEL_W;
   localparam int DW = pba_pkg::WORD_BITS;

   pba_pkg::state_type state_ff, state_in;
   pba_pkg::kind_type kind_ff, kind_in;
   logic [pba_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [WAW-1:0] clr_ff, clr_in;
   logic [SAW-1:0] chk_idx_ff, chk_idx_in;
   logic [WAW-1:0] wi_ff, wi_in;
   pba_pkg::status_type status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [pba_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   pba_pkg::status_type rsp_status_ff, rsp_status_in;

   logic [CW-1:0] limit;
   logic [pba_pkg::PAGE_NUM_W-1:0] page;
   logic page_oor;
   logic slot_free;
   logic [CW-1:0] scan_base;
   logic [BW-1:0] free_bit;
   logic [BW-1:0] bit_sel;
   logic [BW-1:0] sum_bit;
   logic [CW-1:0] alloc_page;
   logic alloc_oor;
   logic [DW-1:0] new_word;
   logic [DW-1:0] new_sum;
   logic [WAW-1:0] found_word;

   always_comb begin
      if (CW'(page_count) > CW'(MAX_PAGES)) begin
         limit = CW'(MAX_PAGES);
      end else begin
         limit = CW'(page_count);
      end
      page = addr_ff[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SHIFT];
      page_oor = {1'b0, page} >= limit;
      slot_free = !rsp_valid_ff || rsp_ch.ready;
      scan_base = CW'({chk_idx_ff, 10'b0});
      found_word = WAW'({chk_idx_ff, pba_pkg::first_set(sum_rd_data)});
      free_bit = pba_pkg::first_set(~bm_rd_data);
      alloc_page = CW'({wi_ff, free_bit});
      alloc_oor = alloc_page >= limit;
      bit_sel = (kind_ff == pba_pkg::KIND_ALLOC) ? free_bit : page[BW-1:0];
      if (kind_ff == pba_pkg::KIND_FREE) begin
         new_word = bm_rd_data & ~(DW'(1) << bit_sel);
      end else begin
         new_word = bm_rd_data | (DW'(1) << bit_sel);
      end
      sum_bit = BW'(wi_ff);
      new_sum = (sum_rd_data & ~(DW'(1) << sum_bit))
              | (DW'(new_word != '1) << sum_bit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pba_pkg::S_INIT;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      addr_ff <= addr_in;
      chk_idx_ff <= chk_idx_in;
      wi_ff <= wi_in;
      status_ff <= status_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      addr_in = addr_ff;
      clr_in = clr_ff;
      chk_idx_in = chk_idx_ff;
      wi_in = wi_ff;
      status_in = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_addr_in = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      req_ch.ready = 1'b0;
      bm_wr_en = 1'b0;
      bm_wr_addr = wi_ff;
      bm_wr_data = new_word;
      bm_rd_en = 1'b0;
      bm_rd_addr = WAW'(page >> 5);
      sum_wr_en = 1'b0;
      sum_wr_addr = SAW'(wi_ff >> 5);
      sum_wr_data = new_sum;
      sum_rd_en = 1'b0;
      sum_rd_addr = SAW'(page >> 10);

      unique case (state_ff)
         pba_pkg::S_INIT: begin
            bm_wr_en = 1'b1;
            bm_wr_addr = clr_ff;
            bm_wr_data = '1;
            sum_wr_en = clr_ff < SUM_WORDS;
            sum_wr_addr = SAW'(clr_ff);
            sum_wr_data = '0;
            clr_in = clr_ff + WAW'(1);
            if (clr_ff == WAW'(WORDS - 1)) begin
               state_in = pba_pkg::S_IDLE;
            end
         end
         pba_pkg::S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               kind_in = req_ch.kind;
               addr_in = req_ch.address;
               state_in = pba_pkg::S_CHECK;
            end
         end
         pba_pkg::S_CHECK: begin
            unique case (kind_ff) inside
               pba_pkg::KIND_ALLOC: begin
                  sum_rd_en = 1'b1;
                  sum_rd_addr = '0;
                  chk_idx_in = '0;
                  state_in = pba_pkg::S_SCAN;
               end
               pba_pkg::KIND_FREE, pba_pkg::KIND_RESERVE: begin
                  if (kind_ff == pba_pkg::KIND_FREE
                      && addr_ff[pba_pkg::PAGE_SHIFT-1:0] != '0) begin
                     status_in = pba_pkg::STATUS_UNALIGNED;
                     state_in = pba_pkg::S_RESPOND;
                  end else if (page_oor) begin
                     status_in = pba_pkg::STATUS_RANGE;
                     state_in = pba_pkg::S_RESPOND;
                  end else begin
                     bm_rd_en = 1'b1;
                     sum_rd_en = 1'b1;
                     wi_in = WAW'(page >> 5);
                     state_in = pba_pkg::S_UPDATE;
                  end
               end
               default: begin
                  status_in = pba_pkg::STATUS_OK;
                  state_in = pba_pkg::S_RESPOND;
               end
            endcase
         end
         pba_pkg::S_SCAN: begin
            if (scan_base >= limit) begin
               status_in = pba_pkg::STATUS_OOM;
               state_in = pba_pkg::S_RESPOND;
            end else if (sum_rd_data != '0) begin
               bm_rd_en = 1'b1;
               bm_rd_addr = found_word;
               wi_in = found_word;
               state_in = pba_pkg::S_UPDATE;
            end else if (chk_idx_ff == SAW'(SUM_WORDS - 1)) begin
               status_in = pba_pkg::STATUS_OOM;
               state_in = pba_pkg::S_RESPOND;
            end else begin
               sum_rd_en = 1'b1;
               sum_rd_addr = chk_idx_ff + SAW'(1);
               chk_idx_in = chk_idx_ff + SAW'(1);
            end
         end
         pba_pkg::S_UPDATE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in = '0;
               rsp_status_in = pba_pkg::STATUS_OK;
               if (kind_ff == pba_pkg::KIND_ALLOC && alloc_oor) begin
                  rsp_status_in = pba_pkg::STATUS_OOM;
               end else begin
                  bm_wr_en = 1'b1;
                  sum_wr_en = 1'b1;
                  if (kind_ff == pba_pkg::KIND_ALLOC) begin
                     rsp_addr_in = pba_pkg::ADDR_W'({wi_ff, free_bit, 12'b0});
                  end
               end
               state_in = pba_pkg::S_IDLE;
            end
         end
         pba_pkg::S_RESPOND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in = '0;
               rsp_status_in = status_ff;
               state_in = pba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pba_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.page_address = rsp_addr_ff;
   assign rsp_ch.status = rsp_status_ff;

endmodule
